>>> hw/rtl/wtsc_pkg.sv
// Shared types, codes and reset values for the wall-triggered search controller.
package wtsc_pkg;

   localparam int TIME_BITS_DEF = 32;
   localparam int NOW_BITS      = 32;
   localparam int CSR_IDX_BITS  = 3;
   localparam int CSR_DATA_BITS = 16;
   localparam int REQ_DATA_BITS = 40;
   localparam int RSP_DATA_BITS = 64;

   localparam logic [14:0] CRAWL_SPEED_RST   = 15'd100;
   localparam logic [14:0] TURN_SPEED_RST    = 15'd80;
   localparam logic [15:0] TURN_TIME_RST     = 16'd1200;
   localparam logic [15:0] WALL_CHECK_RST    = 16'd100;
   localparam logic [3:0]  MAX_TRIES_RST     = 4'd3;
   localparam logic [3:0]  TRIES_SAT         = 4'd15;

   typedef enum logic [1:0] {
      MODE_SEARCH = 2'd0,
      MODE_TRACK  = 2'd1,
      MODE_RESCUE = 2'd2,
      MODE_IDLE   = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      BEEP_NONE      = 2'd0,
      BEEP_REACQUIRE = 2'd1,
      BEEP_EXHAUSTED = 2'd2
   } beep_type;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_CRAWL_SPEED   = 3'd0,
      CSR_TURN_SPEED    = 3'd1,
      CSR_TURN_TIME     = 3'd2,
      CSR_WALL_CHECK    = 3'd3,
      CSR_MAX_TRIES     = 3'd4
   } csr_idx_type;

   typedef enum logic {
      ACT_START = 1'b0,
      ACT_STEP  = 1'b1
   } action_type;

   typedef struct packed {
      logic [14:0] crawl_speed;
      logic [14:0] turn_speed;
      logic [15:0] turn_time_ms;
      logic [15:0] wall_check_ms;
      logic [3:0]  max_tries;
   } cfg_type;

   typedef struct packed {
      mode_type    mode;
      logic        in_turn;
      logic [3:0]  tries_done;
      logic        prev_left;
      logic        prev_right;
   } ctrl_type;

   typedef struct packed {
      logic        last;
      logic [3:0]  attempt_count;
      mode_type    mode_now;
      logic        center_servo;
      beep_type    beep;
      logic [15:0] vel_rot;
      logic [15:0] vel_y;
      logic [15:0] vel_x;
      logic        vel_valid;
   } rsp_type;

endpackage

>>> hw/rtl/wall_triggered_search_controller.sv
// Top level of the wall-triggered search controller.
// An accepted transaction is held in an input register, decided combinationally and its
// results written into a two-entry output buffer, which offers them on the result stream;
// the step is held while the buffer cannot take them. A new transaction is taken every
// cycle while the result stream is not stalled and items have no or one result; a
// stop-then-rotate pair holds off the next item until its first result is taken at the
// one-result-per-cycle output port. The input is held off while reset is high.
module wall_triggered_search_controller
   import wtsc_pkg::*;
#(
   parameter int TIME_BITS = TIME_BITS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   // now_ms, wall_left, wall_right, tag_seen, double_click
   input  logic [REQ_DATA_BITS-1:0] req_tdata,
   // action
   input  logic                     req_tuser,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   // vel_valid, vel_x, vel_y, vel_rot, beep, center_servo, mode_now, attempt_count
   output logic [RSP_DATA_BITS-1:0] rsp_tdata,
   output logic                     rsp_tlast,
   input  logic                     csr_we,
   input  logic [CSR_IDX_BITS-1:0]  csr_addr,
   input  logic [CSR_DATA_BITS-1:0] csr_wdata
);

   cfg_type              cfg_ff, cfg_in;
   ctrl_type             ctrl_ff, ctrl_nxt;
   logic [TIME_BITS-1:0] last_check_ff, last_check_nxt;
   logic [TIME_BITS-1:0] turn_begin_ff, turn_begin_nxt;
   logic                 in_vld_ff, in_vld_in;
   action_type           action_ff;
   logic [NOW_BITS-1:0]  now_ff;
   logic                 wall_left_ff;
   logic                 wall_right_ff;
   logic                 tag_seen_ff;
   logic                 double_click_ff;
   logic [1:0]           rsp_count;
   rsp_type              rsp0;
   rsp_type              rsp1;
   logic                 can_load;
   logic                 consume;
   logic                 req_take;

   assign consume    = in_vld_ff && ((rsp_count == 2'd0) || can_load);
   assign req_tready = !reset && (!in_vld_ff || consume);
   assign req_take   = req_tvalid && req_tready;
   assign in_vld_in  = req_take || (in_vld_ff && !consume);

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_addr)
            CSR_CRAWL_SPEED: cfg_in.crawl_speed   = csr_wdata[14:0];
            CSR_TURN_SPEED:  cfg_in.turn_speed    = csr_wdata[14:0];
            CSR_TURN_TIME:   cfg_in.turn_time_ms  = csr_wdata;
            CSR_WALL_CHECK:  cfg_in.wall_check_ms = csr_wdata;
            CSR_MAX_TRIES:   cfg_in.max_tries     = csr_wdata[3:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.crawl_speed   <= CRAWL_SPEED_RST;
         cfg_ff.turn_speed    <= TURN_SPEED_RST;
         cfg_ff.turn_time_ms  <= TURN_TIME_RST;
         cfg_ff.wall_check_ms <= WALL_CHECK_RST;
         cfg_ff.max_tries     <= MAX_TRIES_RST;
         ctrl_ff.mode         <= MODE_IDLE;
         ctrl_ff.in_turn      <= 1'b0;
         ctrl_ff.tries_done   <= 4'd0;
         ctrl_ff.prev_left    <= 1'b0;
         ctrl_ff.prev_right   <= 1'b0;
         last_check_ff        <= '0;
         turn_begin_ff        <= '0;
         in_vld_ff            <= 1'b0;
      end else begin
         cfg_ff    <= cfg_in;
         in_vld_ff <= in_vld_in;
         if (consume) begin
            ctrl_ff       <= ctrl_nxt;
            last_check_ff <= last_check_nxt;
            turn_begin_ff <= turn_begin_nxt;
         end
      end
      if (req_take) begin
         action_ff       <= action_type'(req_tuser);
         now_ff          <= req_tdata[NOW_BITS-1:0];
         wall_left_ff    <= req_tdata[NOW_BITS];
         wall_right_ff   <= req_tdata[NOW_BITS+1];
         tag_seen_ff     <= req_tdata[NOW_BITS+2];
         double_click_ff <= req_tdata[NOW_BITS+3];
      end
   end

   wtsc_step #(
      .TIME_BITS (TIME_BITS)
   ) u_step (
      .cfg            (cfg_ff),
      .ctrl           (ctrl_ff),
      .last_check     (last_check_ff),
      .turn_begin     (turn_begin_ff),
      .action         (action_ff),
      .now_ms         (now_ff),
      .wall_left      (wall_left_ff),
      .wall_right     (wall_right_ff),
      .tag_seen       (tag_seen_ff),
      .double_click   (double_click_ff),
      .ctrl_nxt       (ctrl_nxt),
      .last_check_nxt (last_check_nxt),
      .turn_begin_nxt (turn_begin_nxt),
      .rsp_count      (rsp_count),
      .rsp0           (rsp0),
      .rsp1           (rsp1)
   );

   wtsc_rsp_queue u_rsp_queue (
      .clock      (clock),
      .reset      (reset),
      .load       (consume && (rsp_count != 2'd0)),
      .load_count (rsp_count),
      .load_rsp0  (rsp0),
      .load_rsp1  (rsp1),
      .can_load   (can_load),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

>>> hw/rtl/wtsc_step.sv
// Decision logic for one item: next controller state and up to two results.
module wtsc_step
   import wtsc_pkg::*;
#(
   parameter int TIME_BITS = TIME_BITS_DEF
) (
   input  cfg_type              cfg,
   input  ctrl_type             ctrl,
   input  logic [TIME_BITS-1:0] last_check,
   input  logic [TIME_BITS-1:0] turn_begin,
   input  action_type           action,
   input  logic [NOW_BITS-1:0]  now_ms,
   input  logic                 wall_left,
   input  logic                 wall_right,
   input  logic                 tag_seen,
   input  logic                 double_click,
   output ctrl_type             ctrl_nxt,
   output logic [TIME_BITS-1:0] last_check_nxt,
   output logic [TIME_BITS-1:0] turn_begin_nxt,
   output logic [1:0]           rsp_count,
   output rsp_type              rsp0,
   output rsp_type              rsp1
);

   logic [TIME_BITS-1:0] now_t;
   logic [TIME_BITS-1:0] turn_elapsed;
   logic [TIME_BITS-1:0] check_elapsed;
   logic                 turn_done;
   logic                 check_due;
   logic                 changed;
   logic                 go_left;
   logic [3:0]           tries_inc;
   logic [15:0]          crawl_vel;
   logic [15:0]          turn_vel;

   assign now_t         = TIME_BITS'(now_ms);
   assign turn_elapsed  = now_t - turn_begin;
   assign check_elapsed = now_t - last_check;
   assign turn_done     = turn_elapsed >= TIME_BITS'(cfg.turn_time_ms);
   assign check_due     = check_elapsed >= TIME_BITS'(cfg.wall_check_ms);
   assign changed       = (wall_left != ctrl.prev_left) || (wall_right != ctrl.prev_right);
   assign tries_inc     = (ctrl.tries_done < TRIES_SAT) ? ctrl.tries_done + 4'd1
                                                        : ctrl.tries_done;
   assign crawl_vel     = {1'b0, cfg.crawl_speed};
   assign turn_vel      = {1'b0, cfg.turn_speed};

   always_comb begin
      go_left = (wall_left != ctrl.prev_left);
      if (!wall_left && wall_right) begin
         go_left = 1'b1;
      end
      if (wall_left && !wall_right) begin
         go_left = 1'b0;
      end
   end

   always_comb begin
      ctrl_nxt       = ctrl;
      last_check_nxt = last_check;
      turn_begin_nxt = turn_begin;
      rsp_count      = 2'd0;
      rsp0           = '0;
      rsp0.vel_valid = 1'b1;
      rsp0.beep      = BEEP_NONE;
      rsp0.last      = 1'b1;
      rsp1           = rsp0;

      if (action == ACT_START) begin
         ctrl_nxt.tries_done = 4'd0;
         ctrl_nxt.in_turn    = 1'b0;
         ctrl_nxt.prev_left  = wall_left;
         ctrl_nxt.prev_right = wall_right;
         ctrl_nxt.mode       = MODE_SEARCH;
         last_check_nxt      = now_t;
         rsp0.vel_y          = crawl_vel;
         rsp_count           = 2'd1;
      end else if (ctrl.mode == MODE_SEARCH) begin
         if (double_click) begin
            ctrl_nxt.mode = MODE_RESCUE;
            rsp_count     = 2'd1;
         end else if (tag_seen) begin
            ctrl_nxt.mode     = MODE_TRACK;
            rsp0.beep         = BEEP_REACQUIRE;
            rsp0.center_servo = 1'b1;
            rsp_count         = 2'd1;
         end else if (ctrl.in_turn) begin
            if (turn_done) begin
               ctrl_nxt.in_turn    = 1'b0;
               ctrl_nxt.tries_done = tries_inc;
               rsp0.vel_y          = crawl_vel;
               rsp0.beep           = (tries_inc >= cfg.max_tries) ? BEEP_EXHAUSTED
                                                                  : BEEP_NONE;
               rsp_count           = 2'd1;
            end
         end else if (check_due) begin
            last_check_nxt      = now_t;
            ctrl_nxt.prev_left  = wall_left;
            ctrl_nxt.prev_right = wall_right;
            if (changed && (ctrl.tries_done < cfg.max_tries)) begin
               ctrl_nxt.in_turn = 1'b1;
               turn_begin_nxt   = now_t;
               rsp0.last        = 1'b0;
               rsp1.vel_rot     = go_left ? (16'd0 - turn_vel) : turn_vel;
               rsp_count        = 2'd2;
            end
         end
      end

      rsp0.mode_now      = ctrl_nxt.mode;
      rsp0.attempt_count = ctrl_nxt.tries_done;
      rsp1.mode_now      = ctrl_nxt.mode;
      rsp1.attempt_count = ctrl_nxt.tries_done;
   end

endmodule

>>> hw/rtl/wtsc_rsp_queue.sv
// Two-entry result buffer that drives the result stream.
module wtsc_rsp_queue
   import wtsc_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     load,
   input  logic [1:0]               load_count,
   input  rsp_type                  load_rsp0,
   input  rsp_type                  load_rsp1,
   output logic                     can_load,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [RSP_DATA_BITS-1:0] rsp_tdata,
   output logic                     rsp_tlast
);

   rsp_type    slot0_ff, slot0_in;
   rsp_type    slot1_ff, slot1_in;
   logic [1:0] count_ff, count_in;
   logic       pop;

   assign rsp_tvalid = count_ff != 2'd0;
   assign pop        = rsp_tvalid && rsp_tready;
   assign can_load   = (count_ff == 2'd0) || ((count_ff == 2'd1) && rsp_tready);

   // vel_valid, vel_x, vel_y, vel_rot, beep, center_servo, mode_now, attempt_count
   assign rsp_tdata  = RSP_DATA_BITS'(slot0_ff[$bits(rsp_type)-2:0]);
   assign rsp_tlast  = slot0_ff.last;

   always_comb begin
      slot0_in = slot0_ff;
      slot1_in = slot1_ff;
      count_in = count_ff;
      if (load) begin
         slot0_in = load_rsp0;
         slot1_in = load_rsp1;
         count_in = load_count;
      end else if (pop) begin
         slot0_in = slot1_ff;
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
      slot0_ff <= slot0_in;
      slot1_ff <= slot1_in;
   end

endmodule

>>> tb/tb_wall_triggered_search_controller.sv
// Self-checking testbench for the wall-triggered search controller.
`timescale 1ns / 100ps

module tb_wall_triggered_search_controller;
   import wtsc_pkg::*;

   localparam int SETTLE_CYCLES = 8;
   localparam int DRAIN_LIMIT   = 5000;
   localparam int PREDICTED     = -1;
   localparam int PHASE_ITEMS   = 140;

   typedef struct packed {
      action_type  act;
      logic [31:0] now;
      logic        wl;
      logic        wr;
      logic        tag;
      logic        dbl;
   } step_type;

   typedef struct packed {
      logic [15:0] vy;
      logic [15:0] vrot;
      beep_type    beep;
      logic        servo;
      mode_type    mode;
      logic [3:0]  cnt;
      logic        last;
   } cmd_type;

   typedef struct packed {
      step_type s;
      int       n;
      cmd_type  c;
   } row_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   logic [REQ_DATA_BITS-1:0] req_tdata = '0;
   logic                     req_tuser = 1'b0;
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   logic [RSP_DATA_BITS-1:0] rsp_tdata;
   logic                     rsp_tlast;
   logic                     csr_we = 1'b0;
   csr_idx_type              csr_addr = CSR_CRAWL_SPEED;
   logic [CSR_DATA_BITS-1:0] csr_wdata = '0;

   cfg_type     cfg;
   mode_type    ctl_mode = MODE_IDLE;
   logic        ctl_turning = 1'b0;
   logic [3:0]  ctl_tries = '0;
   logic        ctl_prev_l = 1'b0;
   logic        ctl_prev_r = 1'b0;
   logic [31:0] ctl_check_ms = '0;
   logic [31:0] ctl_turn_ms = '0;

   cmd_type     expected_cmds[$];
   row_type     dir_rows[$];
   logic [31:0] sim_ms = '0;
   int          mismatch_total = 0;
   int          rsp_hold_cycles = 0;
   bit          req_burst = 1'b0;
   bit          rsp_burst = 1'b0;

   wall_triggered_search_controller u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic cmd_type make_cmd(input logic [15:0] vy, input logic [15:0] rot,
                                        input beep_type b, input logic servo,
                                        input logic last);
      cmd_type c;
      c.vy    = vy;
      c.vrot  = rot;
      c.beep  = b;
      c.servo = servo;
      c.mode  = ctl_mode;
      c.cnt   = ctl_tries;
      c.last  = last;
      return c;
   endfunction

   function automatic int steer_predict(input step_type s, output cmd_type r0,
                                        output cmd_type r1);
      logic [31:0] since;
      logic        old_l;
      logic        changed;
      logic        go_left;
      logic [15:0] rot;
      r0 = make_cmd(16'd0, 16'd0, BEEP_NONE, 1'b0, 1'b1);
      r1 = r0;
      if (s.act == ACT_START) begin
         ctl_tries    = '0;
         ctl_turning  = 1'b0;
         ctl_prev_l   = s.wl;
         ctl_prev_r   = s.wr;
         ctl_check_ms = s.now;
         ctl_mode     = MODE_SEARCH;
         r0 = make_cmd({1'b0, cfg.crawl_speed}, 16'd0, BEEP_NONE, 1'b0, 1'b1);
         return 1;
      end
      if (ctl_mode != MODE_SEARCH) return 0;
      if (s.dbl) begin
         ctl_mode = MODE_RESCUE;
         r0 = make_cmd(16'd0, 16'd0, BEEP_NONE, 1'b0, 1'b1);
         return 1;
      end
      if (s.tag) begin
         ctl_mode = MODE_TRACK;
         r0 = make_cmd(16'd0, 16'd0, BEEP_REACQUIRE, 1'b1, 1'b1);
         return 1;
      end
      if (ctl_turning) begin
         since = s.now - ctl_turn_ms;
         if (since < {16'd0, cfg.turn_time_ms}) return 0;
         ctl_turning = 1'b0;
         if (ctl_tries != TRIES_SAT) ctl_tries = ctl_tries + 4'd1;
         r0 = make_cmd({1'b0, cfg.crawl_speed}, 16'd0,
                       (ctl_tries >= cfg.max_tries) ? BEEP_EXHAUSTED : BEEP_NONE, 1'b0, 1'b1);
         return 1;
      end
      since = s.now - ctl_check_ms;
      if (since < {16'd0, cfg.wall_check_ms}) return 0;
      old_l        = ctl_prev_l;
      changed      = (s.wl != ctl_prev_l) || (s.wr != ctl_prev_r);
      ctl_check_ms = s.now;
      ctl_prev_l   = s.wl;
      ctl_prev_r   = s.wr;
      if (!changed || ctl_tries >= cfg.max_tries) return 0;
      go_left = (s.wl != old_l);
      if (!s.wl && s.wr) go_left = 1'b1;
      if (s.wl && !s.wr) go_left = 1'b0;
      rot = go_left ? 16'd0 - {1'b0, cfg.turn_speed} : {1'b0, cfg.turn_speed};
      ctl_turning = 1'b1;
      ctl_turn_ms = s.now;
      r0 = make_cmd(16'd0, 16'd0, BEEP_NONE, 1'b0, 1'b0);
      r1 = make_cmd(16'd0, rot, BEEP_NONE, 1'b0, 1'b1);
      return 2;
   endfunction

   task automatic queue_prediction(input step_type s);
      cmd_type c0;
      cmd_type c1;
      int      n;
      n = steer_predict(s, c0, c1);
      if (n > 0) expected_cmds.push_back(c0);
      if (n > 1) expected_cmds.push_back(c1);
   endtask

   task automatic add_row(input action_type a, input logic [31:0] now, input logic wl,
                          input logic wr, input logic tag, input logic dbl, input int n,
                          input logic [15:0] vy, input logic [15:0] rot, input beep_type b,
                          input logic servo, input mode_type m, input logic [3:0] cnt);
      row_type r;
      r.s.act  = a;
      r.s.now  = now;
      r.s.wl   = wl;
      r.s.wr   = wr;
      r.s.tag  = tag;
      r.s.dbl  = dbl;
      r.n      = n;
      r.c.vy   = vy;
      r.c.vrot = rot;
      r.c.beep = b;
      r.c.servo = servo;
      r.c.mode = m;
      r.c.cnt  = cnt;
      r.c.last = 1'b1;
      dir_rows.push_back(r);
   endtask

   task automatic offer_step(input step_type s, input bit no_gap);
      int gap;
      if ($urandom_range(0, 29) == 0) req_burst = !req_burst;
      gap = (no_gap || req_burst) ? 0 : $urandom_range(0, 18);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {4'd0, s.dbl, s.tag, s.wr, s.wl, s.now};
      req_tuser  <= s.act;
      do @(posedge clock); while (req_tready !== 1'b1);
   endtask

   task automatic wait_drained();
      int n;
      req_tvalid <= 1'b0;
      n = 0;
      while (expected_cmds.size() != 0 && n < DRAIN_LIMIT) begin
         @(posedge clock);
         n++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input csr_idx_type idx, input logic [15:0] v);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= v;
      @(posedge clock);
      case (idx)
         CSR_CRAWL_SPEED: cfg.crawl_speed   = v[14:0];
         CSR_TURN_SPEED:  cfg.turn_speed    = v[14:0];
         CSR_TURN_TIME:   cfg.turn_time_ms  = v;
         CSR_WALL_CHECK:  cfg.wall_check_ms = v;
         CSR_MAX_TRIES:   cfg.max_tries     = v[3:0];
         default: ;
      endcase
   endtask

   task automatic program_regs(input logic [15:0] cs, input logic [15:0] ts,
                               input logic [15:0] tt, input logic [15:0] wc,
                               input logic [15:0] mt);
      write_reg(CSR_CRAWL_SPEED, cs);
      write_reg(CSR_TURN_SPEED, ts);
      write_reg(CSR_TURN_TIME, tt);
      write_reg(CSR_WALL_CHECK, wc);
      write_reg(CSR_MAX_TRIES, mt);
      csr_we <= 1'b0;
   endtask

   task automatic run_random_phase(input int target, input bit pressure, input bit pause_mid);
      int       taken;
      int       fast_left;
      int       r;
      int       tt_ms;
      int       wc_ms;
      bit       ignored;
      step_type s;
      taken     = 0;
      fast_left = 0;
      tt_ms     = int'(cfg.turn_time_ms);
      wc_ms     = int'(cfg.wall_check_ms);
      // stall the result side while starts are offered back to back
      if (pressure) begin
         rsp_hold_cycles = 120;
         fast_left       = 40;
      end
      while (taken < target) begin
         r     = $urandom_range(0, 99);
         s.act = ACT_STEP;
         s.tag = 1'b0;
         s.dbl = 1'b0;
         if (fast_left > 0 || (ctl_mode != MODE_SEARCH && r < 85) || r < 4) begin
            s.act = ACT_START;
            if ($urandom_range(0, 3) == 0) sim_ms = $urandom;
            else sim_ms = sim_ms + $urandom_range(0, wc_ms + 1);
         end else begin
            if (r < 7) begin
               s.dbl = 1'b1;
               s.tag = 1'($urandom_range(0, 1));
            end else if (r < 10) begin
               s.tag = 1'b1;
            end
            if (ctl_turning) begin
               case ($urandom_range(0, 9))
                  0, 1, 2: sim_ms = ctl_turn_ms + tt_ms;
                  3:       sim_ms = ctl_turn_ms + tt_ms - 1;
                  default: sim_ms = sim_ms + $urandom_range(0, tt_ms / 2 + 1);
               endcase
            end else begin
               case ($urandom_range(0, 9))
                  0, 1:    sim_ms = ctl_check_ms + wc_ms;
                  2:       sim_ms = ctl_check_ms + wc_ms - 1;
                  3:       sim_ms = $urandom;
                  default: sim_ms = sim_ms + $urandom_range(0, wc_ms + 1);
               endcase
            end
         end
         s.now = sim_ms;
         if ($urandom_range(0, 9) < 4) begin
            s.wl = 1'($urandom_range(0, 1));
            s.wr = 1'($urandom_range(0, 1));
         end else begin
            s.wl = ctl_prev_l;
            s.wr = ctl_prev_r;
         end
         ignored = (s.act == ACT_STEP) && (ctl_mode != MODE_SEARCH);
         offer_step(s, fast_left > 0);
         queue_prediction(s);
         if (fast_left > 0) fast_left--;
         if (!ignored) begin
            taken++;
            if (pause_mid && taken == target / 2) wait_drained();
         end
      end
   endtask

   initial begin : rsp_side
      cmd_type want;
      logic    ok;
      int      stall;
      while (reset) @(posedge clock);
      forever begin
         if ($urandom_range(0, 29) == 0) rsp_burst = !rsp_burst;
         stall = rsp_burst ? 0 : $urandom_range(0, 18);
         if (rsp_hold_cycles > 0) begin
            stall           = rsp_hold_cycles;
            rsp_hold_cycles = 0;
         end
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (rsp_tvalid !== 1'b1);
         if (expected_cmds.size() == 0) begin
            mismatch_total++;
            if (mismatch_total <= 10)
               $display("ERROR: unpredicted transaction tdata=%h tlast=%b",
                        rsp_tdata, rsp_tlast);
         end else begin
            want = expected_cmds.pop_front();
            ok = (rsp_tdata[0] === 1'b1) && (rsp_tdata[16:1] === 16'd0) &&
                 (rsp_tdata[32:17] === want.vy) && (rsp_tdata[48:33] === want.vrot) &&
                 (rsp_tdata[50:49] === want.beep) && (rsp_tdata[51] === want.servo) &&
                 (rsp_tdata[53:52] === want.mode) && (rsp_tdata[57:54] === want.cnt) &&
                 (rsp_tlast === want.last);
            if (!ok) begin
               mismatch_total++;
               if (mismatch_total <= 10) begin
                  $display("ERROR: want vy=%h rot=%h beep=%0d servo=%b mode=%0d cnt=%0d last=%b",
                           want.vy, want.vrot, want.beep, want.servo, want.mode, want.cnt,
                           want.last);
                  $display("       got  vy=%h rot=%h beep=%0d servo=%b mode=%0d cnt=%0d last=%b",
                           rsp_tdata[32:17], rsp_tdata[48:33], rsp_tdata[50:49], rsp_tdata[51],
                           rsp_tdata[53:52], rsp_tdata[57:54], rsp_tlast);
                  $display("       got  vv=%b vx=%h", rsp_tdata[0], rsp_tdata[16:1]);
               end
            end
         end
      end
   end

   initial begin : req_side
      cmd_type c0;
      cmd_type c1;
      int      ph;
      cfg.crawl_speed   = CRAWL_SPEED_RST;
      cfg.turn_speed    = TURN_SPEED_RST;
      cfg.turn_time_ms  = TURN_TIME_RST;
      cfg.wall_check_ms = WALL_CHECK_RST;
      cfg.max_tries     = MAX_TRIES_RST;

      //      action     now_ms         wl wr tg dc  results    vy      rot     beep
      add_row(ACT_STEP,  32'd0,         0, 0, 0, 0, 0,         16'd0,   16'd0, BEEP_NONE,
              0, MODE_IDLE, 4'd0);
      add_row(ACT_START, 32'd0,         0, 0, 0, 0, 1,         16'd100, 16'd0, BEEP_NONE,
              0, MODE_SEARCH, 4'd0);
      add_row(ACT_STEP,  32'd50,        1, 0, 0, 0, PREDICTED, 16'd0,   16'd0, BEEP_NONE,
              0, MODE_IDLE, 4'd0);
      add_row(ACT_STEP,  32'd100,       1, 0, 0, 0, PREDICTED, 16'd0,   16'd0, BEEP_NONE,
              0, MODE_IDLE, 4'd0);
      add_row(ACT_STEP,  32'd500,       1, 0, 0, 0, PREDICTED, 16'd0,   16'd0, BEEP_NONE,
              0, MODE_IDLE, 4'd0);
      add_row(ACT_STEP,  32'd1300,      1, 0, 0, 0, PREDICTED, 16'd0,   16'd0, BEEP_NONE,
              0, MODE_IDLE, 4'd0);
      add_row(ACT_STEP,  32'd1450,      0, 1, 0, 0, PREDICTED, 16'd0,   16'd0, BEEP_NONE,
              0, MODE_IDLE, 4'd0);
      add_row(ACT_STEP,  32'd2650,      0, 1, 0, 0, PREDICTED, 16'd0,   16'd0, BEEP_NONE,
              0, MODE_IDLE, 4'd0);
      add_row(ACT_STEP,  32'd2800,      1, 1, 0, 0, PREDICTED, 16'd0,   16'd0, BEEP_NONE,
              0, MODE_IDLE, 4'd0);
      add_row(ACT_STEP,  32'd4000,      1, 1, 0, 0, PREDICTED, 16'd0,   16'd0, BEEP_NONE,
              0, MODE_IDLE, 4'd0);
      add_row(ACT_STEP,  32'd4200,      0, 0, 0, 0, PREDICTED, 16'd0,   16'd0, BEEP_NONE,
              0, MODE_IDLE, 4'd0);
      add_row(ACT_STEP,  32'd4210,      0, 0, 1, 0, 1,         16'd0,   16'd0, BEEP_REACQUIRE,
              1, MODE_TRACK, 4'd3);
      add_row(ACT_STEP,  32'd4300,      0, 0, 0, 0, 0,         16'd0,   16'd0, BEEP_NONE,
              0, MODE_IDLE, 4'd0);
      add_row(ACT_START, 32'hFFFF_FFF0, 1, 1, 0, 0, 1,         16'd100, 16'd0, BEEP_NONE,
              0, MODE_SEARCH, 4'd0);
      add_row(ACT_STEP,  32'h0000_0060, 1, 0, 0, 0, PREDICTED, 16'd0,   16'd0, BEEP_NONE,
              0, MODE_IDLE, 4'd0);
      add_row(ACT_STEP,  32'h0000_050F, 1, 0, 0, 0, PREDICTED, 16'd0,   16'd0, BEEP_NONE,
              0, MODE_IDLE, 4'd0);
      add_row(ACT_STEP,  32'h0000_0510, 1, 0, 0, 0, PREDICTED, 16'd0,   16'd0, BEEP_NONE,
              0, MODE_IDLE, 4'd0);
      add_row(ACT_STEP,  32'h0000_0600, 1, 0, 1, 1, 1,         16'd0,   16'd0, BEEP_NONE,
              0, MODE_RESCUE, 4'd1);
      add_row(ACT_STEP,  32'h0000_0700, 0, 1, 1, 0, 0,         16'd0,   16'd0, BEEP_NONE,
              0, MODE_IDLE, 4'd0);
      add_row(ACT_START, 32'hFFFF_FFFF, 0, 1, 0, 0, 1,         16'd100, 16'd0, BEEP_NONE,
              0, MODE_SEARCH, 4'd0);
      add_row(ACT_STEP,  32'hFFFF_FFFF, 1, 0, 0, 0, PREDICTED, 16'd0,   16'd0, BEEP_NONE,
              0, MODE_IDLE, 4'd0);
      add_row(ACT_STEP,  32'h0000_0063, 0, 0, 0, 0, PREDICTED, 16'd0,   16'd0, BEEP_NONE,
              0, MODE_IDLE, 4'd0);
      add_row(ACT_STEP,  32'h0000_1000, 0, 0, 0, 1, 1,         16'd0,   16'd0, BEEP_NONE,
              0, MODE_RESCUE, 4'd0);

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_rows[i]) begin
         offer_step(dir_rows[i].s, 1'b0);
         if (dir_rows[i].n == PREDICTED) begin
            queue_prediction(dir_rows[i].s);
         end else begin
            void'(steer_predict(dir_rows[i].s, c0, c1));
            if (dir_rows[i].n > 0) expected_cmds.push_back(dir_rows[i].c);
         end
      end

      wait_drained();
      program_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      run_random_phase(PHASE_ITEMS, 1'b0, 1'b0);

      wait_drained();
      program_regs(16'h8000, 16'h8000, 16'h0000, 16'h0000, 16'hFFF0);
      run_random_phase(PHASE_ITEMS, 1'b1, 1'b0);

      for (ph = 0; ph < 4; ph++) begin
         wait_drained();
         program_regs(16'($urandom), 16'($urandom), 16'($urandom_range(0, 3000)),
                      16'($urandom_range(0, 400)), {12'($urandom), 4'($urandom_range(1, 15))});
         run_random_phase(PHASE_ITEMS, 1'b0, ph == 1);
      end

      wait_drained();
      mismatch_total += expected_cmds.size();
      if (mismatch_total == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

   initial begin : watchdog
      #5_000_000;
      $display("Mismatches found");
      $finish;
   end

endmodule
